// File: rtl/core/phase_vocoder_resynth_bin_defines.svh
// ----------------------------------------------------------------------------
// Phase vocoder resynthesis bin - assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef PHASE_VOCODER_RESYNTH_BIN_DEFINES_SVH
`define PHASE_VOCODER_RESYNTH_BIN_DEFINES_SVH

// consequent in the same cycle
`define PVRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the next cycle
`define PVRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pvrb_pkg.sv
// ----------------------------------------------------------------------------
// Phase vocoder resynthesis bin - package
// Widths, register indexes, word types and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package pvrb_pkg;

   localparam int MAX_HALF_SIZE = 512;
   localparam int STORE_DEPTH   = MAX_HALF_SIZE + 1;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int FILL_W        = $clog2(STORE_DEPTH + 1);
   localparam int BIN_W         = 10;
   localparam int AMP_W         = 16;
   localparam int FREQ_W        = 32;
   localparam int PHASE_W       = 32;
   localparam int CFG_W         = 32;
   localparam int OUT_W         = 17;
   localparam int OUT_MAX       = 65535;
   localparam int DEV_W         = 40;
   localparam int DEV_HALF      = DEV_W / 2;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 48;
   localparam int CSR_ADDR_W    = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_HALF_SIZE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BIN_SPACING  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TURNS_PER_HZ = 2'd2;
   localparam logic [BIN_W-1:0]      HALF_SIZE_RESET  = 10'd256;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CORDIC_STAGES = 24;
   localparam int STAGE_W       = $clog2(CORDIC_STAGES);
   localparam int CW            = 35;
   localparam int ZW            = 34;
   localparam logic [31:0] KINV = 32'd2608131496;

   typedef struct packed {
      logic [AMP_W-1:0]         amp;
      logic signed [FREQ_W-1:0] freq;
      logic [BIN_W-1:0]         bin;
      logic                     nyq;
      logic                     seen;
   } item_type;

   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic             nyq;
      logic             flip;
   } meta_type;

   function automatic logic signed [ZW-1:0] atan_turn(input logic [STAGE_W-1:0] i);
      logic signed [ZW-1:0] v;
      unique case (i)
         5'd0:    v = 34'sd536870912;
         5'd1:    v = 34'sd316933406;
         5'd2:    v = 34'sd167458907;
         5'd3:    v = 34'sd85004756;
         5'd4:    v = 34'sd42667331;
         5'd5:    v = 34'sd21354465;
         5'd6:    v = 34'sd10679838;
         5'd7:    v = 34'sd5340245;
         5'd8:    v = 34'sd2670163;
         5'd9:    v = 34'sd1335087;
         5'd10:   v = 34'sd667544;
         5'd11:   v = 34'sd333772;
         5'd12:   v = 34'sd166886;
         5'd13:   v = 34'sd83443;
         5'd14:   v = 34'sd41722;
         5'd15:   v = 34'sd20861;
         5'd16:   v = 34'sd10430;
         5'd17:   v = 34'sd5215;
         5'd18:   v = 34'sd2608;
         5'd19:   v = 34'sd1304;
         5'd20:   v = 34'sd652;
         5'd21:   v = 34'sd326;
         5'd22:   v = 34'sd163;
         5'd23:   v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/pvrb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pvrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 513
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/pvrb_front.sv
// ----------------------------------------------------------------------------
// Phase vocoder resynthesis bin - front end
// Accept words, number the bins, mark Nyquist and first-visit bins.
// ----------------------------------------------------------------------------
`default_nettype none

module pvrb_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic [pvrb_pkg::AMP_W-1:0]       in_amp,
   input  wire logic signed [pvrb_pkg::FREQ_W-1:0] in_freq,
   input  wire logic [pvrb_pkg::BIN_W-1:0]       half_size,
   input  wire logic                             queue_full,
   output logic                                  push,
   output pvrb_pkg::item_type                    item
);

   logic [pvrb_pkg::BIN_W-1:0]  counter_ff, counter_in;
   logic [pvrb_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [pvrb_pkg::BIN_W-1:0]  eff;
   logic [pvrb_pkg::BIN_W-1:0]  bin;
   logic                        nyq;

   always_comb begin
      priority if (half_size == '0) begin
         eff = pvrb_pkg::BIN_W'(1);
      end else if (half_size > pvrb_pkg::BIN_W'(pvrb_pkg::MAX_HALF_SIZE)) begin
         eff = pvrb_pkg::BIN_W'(pvrb_pkg::MAX_HALF_SIZE);
      end else begin
         eff = half_size;
      end
      bin = (counter_ff >= eff) ? eff : counter_ff;
      nyq = (bin == eff);
   end

   assign in_ready = !queue_full;
   assign push     = in_valid && in_ready;

   assign item.amp  = in_amp;
   assign item.freq = in_freq;
   assign item.bin  = bin;
   assign item.nyq  = nyq;
   assign item.seen = pvrb_pkg::FILL_W'(bin) < fill_ff;

   always_comb begin
      counter_in = counter_ff;
      fill_in    = fill_ff;
      if (push) begin
         counter_in = nyq ? '0 : bin + pvrb_pkg::BIN_W'(1);
         if (pvrb_pkg::FILL_W'(bin) == fill_ff) begin
            fill_in = fill_ff + pvrb_pkg::FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         fill_ff    <= '0;
      end else begin
         counter_ff <= counter_in;
         fill_ff    <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/pvrb_queue.sv
// ----------------------------------------------------------------------------
// Phase vocoder resynthesis bin - bin queue
// Short first-in first-out queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pvrb_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  pvrb_pkg::item_type      push_item,
   input  wire logic               pop,
   output pvrb_pkg::item_type      pop_item,
   output logic                    full,
   output logic                    empty
);

   pvrb_pkg::item_type               slot_ff [0:pvrb_pkg::QUEUE_DEPTH-1];
   logic [pvrb_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pvrb_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pvrb_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full     = (count_ff == pvrb_pkg::QCNT_W'(pvrb_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + pvrb_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + pvrb_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + pvrb_pkg::QCNT_W'(push) - pvrb_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/pvrb_back.sv
// ----------------------------------------------------------------------------
// Phase vocoder resynthesis bin - back end
// Deviation, phase increment, phase store update, CORDIC and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module pvrb_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 q_empty,
   input  pvrb_pkg::item_type                        q_item,
   output logic                                      q_pop,
   input  wire logic [pvrb_pkg::CFG_W-1:0]           bin_spacing,
   input  wire logic [pvrb_pkg::CFG_W-1:0]           turns_per_hz,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output logic [pvrb_pkg::BIN_W-1:0]                out_bin,
   output logic signed [pvrb_pkg::OUT_W-1:0]         out_real,
   output logic signed [pvrb_pkg::OUT_W-1:0]         out_imag,
   output logic                                      out_imag_valid,
   output logic                                      out_frame_end
);

   localparam int TSP_W = pvrb_pkg::BIN_W + pvrb_pkg::CFG_W;
   localparam int PLO_W = pvrb_pkg::DEV_HALF + pvrb_pkg::CFG_W;
   localparam int XP_W  = pvrb_pkg::AMP_W + 32;
   localparam int RND_W = pvrb_pkg::CW - 15;

   logic adv;

   // stage 1: queue word
   logic               s1_vld_ff;
   pvrb_pkg::item_type s1_ff;
   // stage 2: bin times spacing
   logic                                s2_vld_ff;
   pvrb_pkg::item_type                  s2_ff;
   logic [TSP_W-1:0]                    s2_tsp_ff;
   // stage 3: deviation
   logic                                s3_vld_ff;
   pvrb_pkg::item_type                  s3_ff;
   logic [pvrb_pkg::DEV_W-1:0]          s3_dev_ff;
   // stage 4: partial products, start vector
   logic                                s4_vld_ff;
   pvrb_pkg::item_type                  s4_ff;
   logic [pvrb_pkg::DEV_W-1:0]          s4_plo_ff;
   logic [pvrb_pkg::DEV_HALF-1:0]       s4_phi_ff;
   logic [31:0]                         s4_x0_ff;
   // stage 5: increment, stored phase read
   logic                                s5_vld_ff;
   pvrb_pkg::item_type                  s5_ff;
   logic [pvrb_pkg::PHASE_W-1:0]        s5_inc_ff;
   logic [31:0]                         s5_x0_ff;

   logic [PLO_W-1:0]                    plo_full;
   logic [XP_W-1:0]                     xprod;
   logic [pvrb_pkg::DEV_W-1:0]          inc_sum;
   logic [pvrb_pkg::PHASE_W-1:0]        rd_phase;
   logic [pvrb_pkg::PHASE_W-1:0]        phase;
   logic [pvrb_pkg::PHASE_W-1:0]        phase_fold;
   logic                                flip;

   logic                                cv_ff [0:pvrb_pkg::CORDIC_STAGES];
   logic signed [pvrb_pkg::CW-1:0]      cx_ff [0:pvrb_pkg::CORDIC_STAGES];
   logic signed [pvrb_pkg::CW-1:0]      cy_ff [0:pvrb_pkg::CORDIC_STAGES];
   logic signed [pvrb_pkg::ZW-1:0]      cz_ff [0:pvrb_pkg::CORDIC_STAGES];
   pvrb_pkg::meta_type                  cm_ff [0:pvrb_pkg::CORDIC_STAGES];

   logic signed [pvrb_pkg::OUT_W-1:0]   cos_r, sin_r;

   logic                                out_vld_ff;
   logic [pvrb_pkg::BIN_W-1:0]          out_bin_ff;
   logic signed [pvrb_pkg::OUT_W-1:0]   out_real_ff, out_imag_ff;
   logic                                out_nyq_ff;

   function automatic logic signed [pvrb_pkg::OUT_W-1:0] round_sat(
      input logic signed [pvrb_pkg::CW-1:0] v);
      logic signed [pvrb_pkg::CW:0] s;
      logic signed [RND_W-1:0]      r;
      logic signed [RND_W-1:0]      lim;
      logic signed [RND_W-1:0]      nlim;
      logic signed [RND_W-1:0]      q;
      s    = {v[pvrb_pkg::CW-1], v} + (pvrb_pkg::CW + 1)'(32768);
      r    = s[pvrb_pkg::CW:16];
      lim  = RND_W'(pvrb_pkg::OUT_MAX);
      nlim = -lim;
      priority if (r > lim) begin
         q = lim;
      end else if (r < nlim) begin
         q = nlim;
      end else begin
         q = r;
      end
      return q[pvrb_pkg::OUT_W-1:0];
   endfunction

   assign adv   = !out_vld_ff || out_ready;
   assign q_pop = adv && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= !q_empty;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   assign plo_full = s3_dev_ff[pvrb_pkg::DEV_HALF-1:0] * turns_per_hz;
   assign xprod    = s3_ff.amp * pvrb_pkg::KINV;
   assign inc_sum  = s4_plo_ff + {s4_phi_ff, {pvrb_pkg::DEV_HALF{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff     <= q_item;
         s2_ff     <= s1_ff;
         s2_tsp_ff <= s1_ff.bin * bin_spacing;
         s3_ff     <= s2_ff;
         s3_dev_ff <= pvrb_pkg::DEV_W'(s2_ff.freq) - s2_tsp_ff[pvrb_pkg::DEV_W-1:0];
         s4_ff     <= s3_ff;
         s4_plo_ff <= plo_full[pvrb_pkg::DEV_W-1:0];
         s4_phi_ff <= pvrb_pkg::DEV_HALF'(
                         s3_dev_ff[pvrb_pkg::DEV_W-1:pvrb_pkg::DEV_HALF]
                         * turns_per_hz[pvrb_pkg::DEV_HALF-1:0]);
         s4_x0_ff  <= xprod[XP_W-1:16];
         s5_ff     <= s4_ff;
         s5_inc_ff <= inc_sum[pvrb_pkg::DEV_W-1:8];
         s5_x0_ff  <= s4_x0_ff;
      end
   end

   pvrb_ram #(
      .WIDTH (pvrb_pkg::PHASE_W),
      .DEPTH (pvrb_pkg::STORE_DEPTH)
   ) u_phase_store (
      .clock   (clock),
      .wr_en   (adv && s5_vld_ff),
      .wr_addr (pvrb_pkg::ADDR_W'(s5_ff.bin)),
      .wr_data (phase),
      .rd_en   (adv),
      .rd_addr (pvrb_pkg::ADDR_W'(s4_ff.bin)),
      .rd_data (rd_phase)
   );

   always_comb begin
      phase      = (s5_ff.seen ? rd_phase : '0) + s5_inc_ff;
      flip       = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      phase_fold = flip ? phase - 32'h8000_0000 : phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]      <= pvrb_pkg::CW'(s5_x0_ff);
         cy_ff[0]      <= '0;
         cz_ff[0]      <= pvrb_pkg::ZW'($signed(phase_fold));
         cm_ff[0].bin  <= s5_ff.bin;
         cm_ff[0].nyq  <= s5_ff.nyq;
         cm_ff[0].flip <= flip;
      end
   end

   for (genvar k = 0; k < pvrb_pkg::CORDIC_STAGES; k++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cm_ff[k+1] <= cm_ff[k];
            if (!cz_ff[k][pvrb_pkg::ZW-1]) begin
               cx_ff[k+1] <= cx_ff[k] - (cy_ff[k] >>> k);
               cy_ff[k+1] <= cy_ff[k] + (cx_ff[k] >>> k);
               cz_ff[k+1] <= cz_ff[k] - pvrb_pkg::atan_turn(pvrb_pkg::STAGE_W'(k));
            end else begin
               cx_ff[k+1] <= cx_ff[k] + (cy_ff[k] >>> k);
               cy_ff[k+1] <= cy_ff[k] - (cx_ff[k] >>> k);
               cz_ff[k+1] <= cz_ff[k] + pvrb_pkg::atan_turn(pvrb_pkg::STAGE_W'(k));
            end
         end
      end
   end

   always_comb begin
      cos_r = round_sat(cx_ff[pvrb_pkg::CORDIC_STAGES]);
      sin_r = round_sat(cy_ff[pvrb_pkg::CORDIC_STAGES]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= cv_ff[pvrb_pkg::CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_bin_ff  <= cm_ff[pvrb_pkg::CORDIC_STAGES].bin;
         out_nyq_ff  <= cm_ff[pvrb_pkg::CORDIC_STAGES].nyq;
         out_real_ff <= cm_ff[pvrb_pkg::CORDIC_STAGES].flip ? -cos_r : cos_r;
         if (cm_ff[pvrb_pkg::CORDIC_STAGES].nyq) begin
            out_imag_ff <= '0;
         end else begin
            out_imag_ff <= cm_ff[pvrb_pkg::CORDIC_STAGES].flip ? sin_r : -sin_r;
         end
      end
   end

   assign out_valid      = out_vld_ff;
   assign out_bin        = out_bin_ff;
   assign out_real       = out_real_ff;
   assign out_imag       = out_imag_ff;
   assign out_imag_valid = !out_nyq_ff;
   assign out_frame_end  = out_nyq_ff;

endmodule

`default_nettype wire

// File: rtl/core/phase_vocoder_resynth_bin.sv
// ----------------------------------------------------------------------------
// Phase vocoder resynthesis bin - top level
// Per-bin phase accumulation and polar to rectangular conversion.
// ----------------------------------------------------------------------------
// One bin word is taken per clock and one result word leaves per clock when
// the output side keeps up; each bin passes the deviation multiply, the
// phase store read and the 24-step CORDIC pipeline in turn. A four-word
// queue sits between the bin numbering front end and the pipeline, and it
// lets new bins enter while a finished word waits in the result register.
// The phase store needs no clearing pass after reset: a fill count marks
// which bins hold an accumulated phase, and the others read as zero.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_vocoder_resynth_bin (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // amplitude[15:0], freq_hz[47:16]
   input  wire logic [pvrb_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // bin_number[9:0], real_part[26:10], imag_part[43:27], zeros[47:44]
   output logic [pvrb_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // imag_valid[0]
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_we,
   input  wire logic [pvrb_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [pvrb_pkg::CFG_W-1:0]          csr_wdata
);

   logic [pvrb_pkg::BIN_W-1:0]        half_size_ff, half_size_in;
   logic [pvrb_pkg::CFG_W-1:0]        spacing_ff, spacing_in;
   logic [pvrb_pkg::CFG_W-1:0]        turns_ff, turns_in;

   logic                              push, pop, q_full, q_empty;
   pvrb_pkg::item_type                push_item, pop_item;

   logic [pvrb_pkg::BIN_W-1:0]        out_bin;
   logic signed [pvrb_pkg::OUT_W-1:0] out_real, out_imag;
   logic                              out_imag_valid, out_frame_end;

   always_comb begin
      half_size_in = half_size_ff;
      spacing_in   = spacing_ff;
      turns_in     = turns_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pvrb_pkg::REG_HALF_SIZE:    half_size_in = csr_wdata[pvrb_pkg::BIN_W-1:0];
            pvrb_pkg::REG_BIN_SPACING:  spacing_in   = csr_wdata;
            pvrb_pkg::REG_TURNS_PER_HZ: turns_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_size_ff <= pvrb_pkg::HALF_SIZE_RESET;
         spacing_ff   <= '0;
         turns_ff     <= '0;
      end else begin
         half_size_ff <= half_size_in;
         spacing_ff   <= spacing_in;
         turns_ff     <= turns_in;
      end
   end

   pvrb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_amp     (req_tdata[15:0]),
      .in_freq    ($signed(req_tdata[47:16])),
      .half_size  (half_size_ff),
      .queue_full (q_full),
      .push       (push),
      .item       (push_item)
   );

   pvrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   pvrb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (pop_item),
      .q_pop          (pop),
      .bin_spacing    (spacing_ff),
      .turns_per_hz   (turns_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_bin        (out_bin),
      .out_real       (out_real),
      .out_imag       (out_imag),
      .out_imag_valid (out_imag_valid),
      .out_frame_end  (out_frame_end)
   );

   assign rsp_tdata = {4'b0000, out_imag, out_real, out_bin};
   assign rsp_tuser = out_imag_valid;
   assign rsp_tlast = out_frame_end;

endmodule

`default_nettype wire

// File: rtl/core/pvrb_checker.sv
// ----------------------------------------------------------------------------
// Phase vocoder resynthesis bin - port checker
// Watch the result side of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "phase_vocoder_resynth_bin_defines.svh"

module pvrb_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [pvrb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                               rsp_tuser,
   input wire logic                               rsp_tlast
);

   `PVRB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result word dropped")
   `PVRB_ASSERT_NOW(a_tuser_tlast, rsp_tvalid, rsp_tuser != rsp_tlast, "imag flag vs frame end")
   `PVRB_ASSERT_NOW(a_nyq_imag, rsp_tvalid && rsp_tlast, rsp_tdata[43:27] == 17'd0, "Nyquist imag set")
   `PVRB_ASSERT_NOW(a_reset_quiet, $past(reset), !rsp_tvalid, "result right after reset")

endmodule

bind phase_vocoder_resynth_bin pvrb_checker u_pvrb_checker (.*);

`default_nettype wire
